/* design/wlc_pkg.sv */
`default_nettype none
package wlc_pkg;
  localparam int WindowSlots = 16;
  localparam int SlotBits = 4;
  localparam int CoordBits = 12;
  localparam int SizeBits = 13;
  localparam logic [23:0] DefaultBackground = 24'h282828;

  typedef enum logic [1:0] {
    KIND_BACKGROUND = 2'd0,
    KIND_BORDER     = 2'd1,
    KIND_CONTENT    = 2'd2,
    KIND_OUTSIDE    = 2'd3
  } pixel_kind_t;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CoordBits-1:0] left;
    logic [CoordBits-1:0] top;
    logic [SizeBits-1:0]  width;
    logic [SizeBits-1:0]  height;
    logic [CoordBits-1:0] border;
    logic [23:0]          color;
    logic [3:0]           order;
    logic                 shown;
  } slot_t;
endpackage
`default_nettype wire

/* design/wlc_slots.sv */
`default_nettype none
// slot table, written from the item stream; read by hit logic in parallel
module wlc_slots
  import wlc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [SlotBits-1:0] wr_slot,
  input  wire slot_t               wr_data,
  output slot_t                    slots [WindowSlots]
);
  slot_t table_q [WindowSlots];
  logic [WindowSlots-1:0] shown_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_q[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_q <= '0;
    end else if (wr_en) begin
      shown_q[wr_slot] <= wr_data.shown;
    end
  end

  always_comb begin
    for (int i = 0; i < WindowSlots; i++) begin
      slots[i] = table_q[i];
      slots[i].shown = shown_q[i];
    end
  end
endmodule
`default_nettype wire

/* design/window_layer_compositor.sv */
`default_nettype none
// window layer compositor
// s_axis carries items: a pixel query (action 0) or a slot write (action 1).
// a write is held in stage 1 and loads its window slot as it moves on, so
// later queries see it and earlier ones do not; it gives no beat out.
// a query gives one beat on m_axis.
// pipeline: s1 holds the beat and its screen test, s2 registers per-slot
// cover bits, s3 picks the winner with a compare tree and takes its slot data,
// s4 decides border or content into the output register.
// the beat is registered through s1, s2, s3 and the output register on its way
// to m_axis; one item per cycle while m_axis is not stalled.
// cfg writes registers 0..2 (screen width, height, background); the user must write only while idle, not enforced.
// reset clears shown bits and the pipeline; the registers take their defaults.
// a stall on m_axis holds every stage; s_axis_tready drops while the output
// holds a beat that the receiver does not take.
module window_layer_compositor
  import wlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[0] slot[4:1] pos_x[16:5] pos_y[28:17] rect_width[41:29]
  // rect_height[54:42] border_width[66:55] border_color[90:67]
  // layer_order[94:91] shown[95]
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_kind[1:0] pixel_color[25:2] layer_slot[29:26] source_row[41:30]
  // source_col[53:42], zero fill to 56
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [SizeBits-1:0] screen_width, screen_height;
  logic [23:0] background_color;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= SizeBits'(1024);
      screen_height <= SizeBits'(768);
      background_color <= DefaultBackground;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width <= cfg_data[SizeBits-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[SizeBits-1:0];
        REG_BACKGROUND:    background_color <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic in_action;
  logic [SlotBits-1:0] in_slot;
  logic [CoordBits-1:0] px, py;
  slot_t wr_data;
  assign in_action = s_axis_tdata[0];
  assign in_slot = s_axis_tdata[4:1];
  assign px = s_axis_tdata[16:5];
  assign py = s_axis_tdata[28:17];
  assign wr_data = '{left: px, top: py, width: s_axis_tdata[41:29],
                     height: s_axis_tdata[54:42], border: s_axis_tdata[66:55],
                     color: s_axis_tdata[90:67], order: s_axis_tdata[94:91],
                     shown: s_axis_tdata[95]};

  // pipeline advance: whole pipe moves unless output full and stalled
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // stage 1: query registered with coords; a write waits here and lands in
  // the table as it leaves, in step with the reads of the queries around it
  logic v1, out1, wv1;
  logic [CoordBits-1:0] x1, y1;
  logic [SlotBits-1:0] wslot1;
  slot_t wdata1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      wv1 <= 1'b0;
    end else if (adv) begin
      v1 <= acc && !in_action;
      wv1 <= acc && in_action;
    end
    if (adv) begin
      x1 <= px; y1 <= py;
      out1 <= ({1'b0, px} >= screen_width) || ({1'b0, py} >= screen_height);
      wslot1 <= in_slot; wdata1 <= wr_data;
    end
  end

  slot_t slots [WindowSlots];
  wlc_slots u_slots (
    .clk(clk), .rst(rst), .wr_en(adv && wv1),
    .wr_slot(wslot1), .wr_data(wdata1), .slots(slots)
  );

  // stage 2: per-slot cover bits registered
  logic [WindowSlots-1:0] cov_next, cov2;
  logic v2, out2;
  logic [CoordBits-1:0] x2, y2;
  always_comb begin
    for (int i = 0; i < WindowSlots; i++) begin
      cov_next[i] = slots[i].shown && slots[i].width != '0 && slots[i].height != '0
        && x1 >= slots[i].left && y1 >= slots[i].top
        && {2'b0, x1} < {2'b0, slots[i].left} + {1'b0, slots[i].width}
        && {2'b0, y1} < {2'b0, slots[i].top} + {1'b0, slots[i].height};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      cov2 <= cov_next; x2 <= x1; y2 <= y1; out2 <= out1;
    end
  end

  // stage 3: winner pick, highest order, ties to higher slot
  // key is {covered, order, slot}; a max tree over the keys finds the winner
  logic hit_next;
  logic [SlotBits-1:0] win_next;
  logic [SlotBits+4:0] pick [2*WindowSlots-1];
  always_comb begin
    for (int i = 0; i < WindowSlots; i++) begin
      pick[WindowSlots-1+i] = {cov2[i], slots[i].order, SlotBits'(i)};
    end
    for (int n = WindowSlots-2; n >= 0; n--) begin
      pick[n] = (pick[2*n+2] >= pick[2*n+1]) ? pick[2*n+2] : pick[2*n+1];
    end
  end
  assign hit_next = pick[0][SlotBits+4];
  assign win_next = pick[0][SlotBits-1:0];
  logic v3, out3, hit3;
  logic [SlotBits-1:0] win3;
  logic [CoordBits-1:0] row3, col3;
  slot_t w3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      out3 <= out2; hit3 <= hit_next; win3 <= win_next;
      w3 <= slots[win_next];
      row3 <= y2 - slots[win_next].top;
      col3 <= x2 - slots[win_next].left;
    end
  end

  // stage 4: border/content decision into output register
  logic content;
  logic [SizeBits:0] rb, cb;
  assign rb = {2'b0, row3} + {2'b0, w3.border};
  assign cb = {2'b0, col3} + {2'b0, w3.border};
  assign content = row3 >= w3.border && col3 >= w3.border
    && rb < {1'b0, w3.height} && cb < {1'b0, w3.width};
  pixel_kind_t kind;
  logic [23:0] color;
  logic [CoordBits-1:0] srow, scol;
  logic [SlotBits-1:0] lslot;
  always_comb begin
    kind = KIND_BACKGROUND; color = background_color; lslot = '0;
    srow = '0; scol = '0;
    if (out3) begin
      kind = KIND_OUTSIDE; color = '0;
    end else if (hit3) begin
      lslot = win3;
      if (content) begin
        kind = KIND_CONTENT; color = '0;
        srow = row3 - w3.border; scol = col3 - w3.border;
      end else begin
        kind = KIND_BORDER; color = w3.color;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v3;
    if (adv) m_axis_tdata <= {2'b0, scol, srow, lslot, color, kind};
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == KIND_OUTSIDE ||
    m_axis_tdata[1:0] == KIND_BACKGROUND) |-> m_axis_tdata[29:26] == '0)
    else $error("slot set without window");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule
`default_nettype wire
